[hdl/lcfs_pkg.sv]
package lcfs_pkg;

  // History depth used when the top level is not overridden.
  localparam int DEF_HISTORY_DEPTH = 16;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_TARE_OFFSET   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_FACTOR  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STABILITY_THR = 2'd3;

  // Request operations.
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TARE   = 1'b1;

  // Configuration reset values.
  localparam logic signed [23:0] TARE_RESET      = 24'sd0;
  localparam logic signed [31:0] SCALE_RESET     = 32'sd65536;
  localparam logic [16:0]        SMOOTHING_RESET = 17'd19661;
  localparam logic [30:0]        THRESHOLD_RESET = 31'd256;

  // Scale factors whose magnitude is below this are replaced by one.
  localparam logic signed [31:0] TINY_FACTOR  = 32'sd66;
  localparam logic signed [31:0] UNITY_FACTOR = 32'sd65536;
  localparam logic [16:0]        UNITY_WEIGHT = 17'd65536;

  // Fewest history entries for which stability can be reported.
  localparam int MIN_STABLE_COUNT = 5;

  // The divider produces one quotient bit per cycle over a 49-bit dividend.
  localparam int DIV_STEPS = 49;
  localparam int DIV_CNT_W = 6;

  typedef struct packed {
    logic              operation;
    logic signed [23:0] sample_value;
  } req_t;

  typedef struct packed {
    logic signed [31:0] current_weight;
    logic signed [31:0] filtered_weight;
    logic               stable;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic div_step;
    logic saturate;
    logic mul;
    logic update;
    logic scan;
    logic load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;
  } status_t;

endpackage

[hdl/lcfs_ctrl.sv]
module lcfs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  logic              req_operation,
  output logic              req_stall,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  input  lcfs_pkg::status_t status,
  output lcfs_pkg::cmd_t    cmd
);
  import lcfs_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_SAT  = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_UPD  = 3'd4;
  localparam logic [2:0] ST_SCAN = 3'd5;
  localparam logic [2:0] ST_OUT  = 3'd6;

  logic [2:0]           state;
  logic [2:0]           state_next;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [DIV_CNT_W-1:0] div_cnt_next;
  logic                 rsp_valid_next;
  logic                 slot_free;

  // The output register can take a new result when empty or being emptied.
  assign slot_free = !rsp_valid || !rsp_stall;
  assign req_stall = (state != ST_IDLE);

  // Sequencing of one item through the datapath.
  always_comb begin
    state_next   = state;
    div_cnt_next = div_cnt;
    cmd          = '0;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          cmd.accept   = 1'b1;
          div_cnt_next = '0;
          state_next   = (req_operation == OP_TARE) ? ST_OUT : ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_next = div_cnt + DIV_CNT_W'(1);
        if (div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_next = ST_SAT;
        end
      end
      ST_SAT: begin
        cmd.saturate = 1'b1;
        state_next   = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_UPD;
      end
      ST_UPD: begin
        cmd.update = 1'b1;
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (slot_free) begin
          cmd.load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Output valid flag: set on load, cleared once the result is transferred.
  always_comb begin
    if (cmd.load) begin
      rsp_valid_next = 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid_next = 1'b0;
    end else begin
      rsp_valid_next = rsp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      div_cnt   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      div_cnt   <= div_cnt_next;
      rsp_valid <= rsp_valid_next;
    end
  end

endmodule

[hdl/lcfs_datapath.sv]
module lcfs_datapath #(
  parameter int HISTORY_DEPTH = lcfs_pkg::DEF_HISTORY_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  lcfs_pkg::cmd_t                    cmd,
  output lcfs_pkg::status_t                 status,
  input  lcfs_pkg::req_t                    req,
  output lcfs_pkg::rsp_t                    rsp,
  input  logic                              cfg_write,
  input  logic [lcfs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [31:0]                       cfg_data
);
  import lcfs_pkg::*;

  localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CW = AW + 1;
  localparam logic signed [49:0] W_MAX = 50'sd2147483647;
  localparam logic signed [49:0] W_MIN = -50'sd2147483648;

  // Configuration registers.
  logic signed [23:0] tare_offset;
  logic signed [31:0] scale_factor;
  logic [16:0]        smoothing_weight;
  logic [30:0]        stability_threshold;

  // Filter state.
  logic signed [31:0] ema_value;
  logic signed [31:0] last_weight;
  logic [AW-1:0]      write_position;
  logic               ring_filled;
  logic [31:0]        history_ring [HISTORY_DEPTH];

  // Divider registers.
  logic [48:0] div_num;
  logic [48:0] div_quo;
  logic [31:0] div_rem;
  logic [31:0] div_den;
  logic        quo_neg;

  // Multiplier and scan registers.
  logic signed [50:0] prod;
  logic [CW-1:0]      scan_cnt;
  logic               scan_rvalid;
  logic               scan_first;
  logic signed [31:0] scan_rdata;
  logic signed [31:0] spread_lo;
  logic signed [31:0] spread_hi;

  // Combinational intermediates.
  logic signed [24:0] diff;
  logic [24:0]        diff_mag;
  logic               factor_tiny;
  logic signed [31:0] factor;
  logic [31:0]        factor_mag;
  logic [32:0]        trial;
  logic               trial_ge;
  logic signed [49:0] quo_signed;
  logic signed [31:0] weight_sat;
  logic [16:0]        alpha;
  logic signed [32:0] delta;
  logic signed [50:0] prod_shifted;
  logic signed [31:0] ema_new;
  logic [CW-1:0]      fill_count;
  logic signed [32:0] spread;
  logic               stable_now;

  // Operand preparation on a sample transfer.
  assign diff        = {req.sample_value[23], req.sample_value} - {tare_offset[23], tare_offset};
  assign diff_mag    = diff[24] ? 25'(-diff) : 25'(diff);
  assign factor_tiny = (scale_factor > -TINY_FACTOR) && (scale_factor < TINY_FACTOR);
  assign factor      = factor_tiny ? UNITY_FACTOR : scale_factor;
  assign factor_mag  = factor[31] ? 32'(-factor) : 32'(factor);

  // One restoring division step.
  assign trial    = {div_rem, div_num[48]};
  assign trial_ge = (trial >= {1'b0, div_den});

  // Sign correction and saturation of the quotient.
  assign quo_signed = quo_neg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
  always_comb begin
    if (quo_signed > W_MAX) begin
      weight_sat = 32'sh7FFFFFFF;
    end else if (quo_signed < W_MIN) begin
      weight_sat = 32'sh80000000;
    end else begin
      weight_sat = quo_signed[31:0];
    end
  end

  // Moving average as ema + floor(alpha * (weight - ema) / 2^16).
  assign alpha        = smoothing_weight[16] ? UNITY_WEIGHT : smoothing_weight;
  assign delta        = {last_weight[31], last_weight} - {ema_value[31], ema_value};
  assign prod_shifted = prod >>> 16;
  assign ema_new      = ema_value + prod_shifted[31:0];

  // Number of valid history entries and the stability decision.
  assign fill_count = ring_filled ? CW'(HISTORY_DEPTH) : {1'b0, write_position};
  assign spread     = {spread_hi[31], spread_hi} - {spread_lo[31], spread_lo};
  assign stable_now = (fill_count >= CW'(MIN_STABLE_COUNT))
                      && (spread <= $signed({2'b00, stability_threshold}));

  assign status.scan_done = (scan_cnt == fill_count);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      tare_offset         <= TARE_RESET;
      scale_factor        <= SCALE_RESET;
      smoothing_weight    <= SMOOTHING_RESET;
      stability_threshold <= THRESHOLD_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_TARE_OFFSET:   tare_offset         <= cfg_data[23:0];
        REG_SCALE_FACTOR:  scale_factor        <= cfg_data;
        REG_SMOOTHING:     smoothing_weight    <= cfg_data[16:0];
        REG_STABILITY_THR: stability_threshold <= cfg_data[30:0];
      endcase
    end
  end

  // Filter state: tare clears the average, an update advances the ring.
  always_ff @(posedge clk) begin
    if (rst) begin
      ema_value      <= '0;
      last_weight    <= '0;
      write_position <= '0;
      ring_filled    <= 1'b0;
    end else begin
      if (cmd.accept && (req.operation == OP_TARE)) begin
        ema_value <= '0;
      end else if (cmd.update) begin
        ema_value <= ema_new;
      end
      if (cmd.saturate) begin
        last_weight <= weight_sat;
      end
      if (cmd.update) begin
        if (write_position == AW'(HISTORY_DEPTH - 1)) begin
          write_position <= '0;
          ring_filled    <= 1'b1;
        end else begin
          write_position <= write_position + AW'(1);
        end
      end
    end
  end

  // Divider: set up on transfer, then one quotient bit per step.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      div_num <= {diff_mag, 24'd0};
      div_quo <= '0;
      div_rem <= '0;
      div_den <= factor_mag;
      quo_neg <= diff[24] ^ factor[31];
    end else if (cmd.div_step) begin
      div_num <= {div_num[47:0], 1'b0};
      if (trial_ge) begin
        div_rem <= 32'(trial - {1'b0, div_den});
        div_quo <= {div_quo[47:0], 1'b1};
      end else begin
        div_rem <= trial[31:0];
        div_quo <= {div_quo[47:0], 1'b0};
      end
    end
  end

  // Registered product for the average update.
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod <= $signed({1'b0, alpha}) * delta;
    end
  end

  // History memory: one write per sample, one read per scan cycle.
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      history_ring[write_position] <= ema_new;
    end
    scan_rdata <= history_ring[scan_cnt[AW-1:0]];
  end

  // Spread scan over the valid entries, read data arriving in the cycle after its address.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_cnt    <= '0;
      scan_rvalid <= 1'b0;
      scan_first  <= 1'b1;
    end else if (cmd.update) begin
      scan_cnt    <= '0;
      scan_rvalid <= 1'b0;
      scan_first  <= 1'b1;
    end else if (cmd.scan) begin
      scan_cnt    <= scan_cnt + CW'(1);
      scan_rvalid <= !status.scan_done;
      if (scan_rvalid) begin
        scan_first <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan && scan_rvalid) begin
      if (scan_first) begin
        spread_lo <= scan_rdata;
        spread_hi <= scan_rdata;
      end else begin
        if (scan_rdata < spread_lo) begin
          spread_lo <= scan_rdata;
        end
        if (scan_rdata > spread_hi) begin
          spread_hi <= scan_rdata;
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rsp.current_weight  <= last_weight;
      rsp.filtered_weight <= ema_value;
      rsp.stable          <= stable_now;
    end
  end

endmodule

[hdl/load_cell_filter_stability_core.sv]
// Load-cell weight filter with stability flag. Each sample transfer on req
// has the tare offset removed, is divided by the Q16.16 scale factor into a
// saturated Q24.8 weight, is smoothed by an exponential moving average and
// the average is stored in a history ring of HISTORY_DEPTH entries; one
// result transfer on rsp follows every request. After a sample transfer
// req_stall stays high through the one-bit-per-cycle divider, saturation,
// multiply and update, the min/max scan over the valid history entries
// (at most HISTORY_DEPTH) through the single read port of the history
// memory, and the load of the output register. A tare request zeroes the
// average and holds req_stall high only for the load step. The load step
// lasts longer while the previous result still waits in the output register
// under rsp_stall; otherwise the output register holds a finished result
// while the next request is taken. Configuration writes are always ready
// and must only be issued while no request is in progress; after reset
// the history is empty, so no clearing pass is needed.
module load_cell_filter_stability_core #(
  parameter int HISTORY_DEPTH = lcfs_pkg::DEF_HISTORY_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_stall,
  input  lcfs_pkg::req_t                 req,
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output lcfs_pkg::rsp_t                 rsp,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lcfs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data
);
  import lcfs_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  // Sequencer.
  lcfs_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_operation (req.operation),
    .req_stall     (req_stall),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .status        (status),
    .cmd           (cmd)
  );

  // Arithmetic, history memory and registers.
  lcfs_datapath #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .req       (req),
    .rsp       (rsp),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

[hdl/lcfs_checker.sv]
module lcfs_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_stall,
  input logic           rsp_valid,
  input logic           rsp_stall,
  input lcfs_pkg::rsp_t rsp
);
  import lcfs_pkg::*;

  // Only one request is in progress at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("request taken while another was in progress");

  // No result can appear in the cycle right after a request transfer.
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall && !rsp_valid) |=> !rsp_valid)
    else $error("result appeared too early after a request transfer");

  // A stalled result stays valid.
  a_rsp_held: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=> rsp_valid)
    else $error("result dropped while stalled");

  // A stalled result does not change.
  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=> $stable(rsp))
    else $error("result changed while stalled");

endmodule

bind load_cell_filter_stability_core lcfs_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);
